// File: hdl/tle_pkg.sv
// ----------------------------------------------------------------------------
// tle_pkg
// Types and constants shared by the line escaper: beat payloads, the group
// record passed from the front to the back, and the byte codes it emits.
// ----------------------------------------------------------------------------
package tle_pkg;

    localparam int LEN_W  = 13;
    localparam int CNT_W  = 7;
    localparam int QDEPTH = 4;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_APOS = 8'h27;
    localparam logic [7:0] CH_LPAR = 8'h28;
    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_Q    = 8'h71;
    localparam logic [7:0] CH_S    = 8'h73;
    localparam logic [6:0] LO_BS   = 7'h08;
    localparam logic [6:0] LO_SPC  = 7'h20;
    localparam logic [6:0] LO_DEL  = 7'h7F;

    typedef enum logic [2:0] {
        K_NONE  = 3'd0,
        K_EMPTY = 3'd1,
        K_PASS  = 3'd2,
        K_BSL   = 3'd3,
        K_TAB   = 3'd4,
        K_SQ    = 3'd5,
        K_PRE   = 3'd6,
        K_END   = 3'd7
    } tle_kind_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } tle_item_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             byte_valid;
        logic             out_last;
        logic [LEN_W-1:0] line_length;
        logic             prefixed;
    } tle_result_t;

    typedef struct packed {
        logic             pre;
        tle_kind_t        a_kind;
        logic [7:0]       a_char;
        logic [CNT_W-1:0] a_cnt;
        tle_kind_t        b_kind;
        logic [7:0]       b_char;
        logic [CNT_W-1:0] b_cnt;
        logic             end_mark;
        logic             last;
        logic [LEN_W-1:0] line_length;
        logic             prefixed;
    } tle_rec_t;

endpackage

// File: hdl/tle_front.sv
// ----------------------------------------------------------------------------
// tle_front
// Accepts raw line bytes, classifies them, tracks column, length and the
// held group, and pushes one group record per beat that produces output.
// ----------------------------------------------------------------------------
module tle_front #(
    parameter int TAB_STOP = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  tle_pkg::tle_item_t         item,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [tle_pkg::LEN_W-1:0]  cfg_data,
    output logic                       rec_push,
    output tle_pkg::tle_rec_t          rec,
    input  logic                       q_full
);
    import tle_pkg::*;

    localparam int RW = $clog2(TAB_STOP);

    logic [LEN_W-1:0] cap_reg, cap_next;
    logic [15:0]      column_reg, column_next;
    logic [RW-1:0]    col_mod_reg, col_mod_next;
    logic [LEN_W-1:0] length_reg, length_next;
    logic [7:0]       held_char_reg, held_char_next;
    tle_kind_t        held_kind_reg, held_kind_next;
    logic [CNT_W-1:0] held_count_reg, held_count_next;
    logic             first_seen_reg, first_seen_next;
    logic             prefix_reg, prefix_next;
    logic             stopped_reg, stopped_next;

    logic             accept;
    logic             pre;
    logic             pflag;
    logic             stp;
    logic [6:0]       low;
    logic [CNT_W-1:0] tab_k;
    tle_kind_t        new_kind;
    logic [7:0]       new_char;
    logic [CNT_W-1:0] new_cnt;
    logic [CNT_W-1:0] new_cols;
    logic [16:0]      col_sum;
    logic [LEN_W:0]   len_need;

    assign accept    = push && !q_full;
    assign full      = q_full;
    assign cfg_ready = 1'b1;
    assign low       = item.in_byte[6:0];
    assign tab_k     = CNT_W'(TAB_STOP) - CNT_W'(col_mod_reg);

    always_comb
    begin
        new_kind = K_PASS;
        new_char = item.in_byte;
        new_cnt  = CNT_W'(1);
        new_cols = CNT_W'(1);
        if (item.in_byte == CH_NUL)
        begin
            new_kind = K_EMPTY;
            new_char = 8'h00;
            new_cnt  = '0;
            new_cols = '0;
        end
        else if (item.in_byte == CH_BSL)
        begin
            new_kind = K_BSL;
            new_char = 8'h00;
            new_cnt  = CNT_W'(2);
        end
        else if (item.in_byte == CH_TAB)
        begin
            new_kind = K_TAB;
            new_char = 8'h00;
            new_cnt  = tab_k;
            new_cols = tab_k;
        end
        else if (item.in_byte == CH_NL)
        begin
            new_kind = K_PASS;
        end
        else if (low < LO_SPC || low == LO_DEL)
        begin
            new_kind = K_SQ;
            new_char = 8'h00;
            new_cnt  = CNT_W'(4);
        end
    end

    assign col_sum = 17'(column_reg) + 17'(new_cols);

    always_comb
    begin
        cap_next        = cap_reg;
        column_next     = column_reg;
        col_mod_next    = col_mod_reg;
        length_next     = length_reg;
        held_char_next  = held_char_reg;
        held_kind_next  = held_kind_reg;
        held_count_next = held_count_reg;
        first_seen_next = first_seen_reg;
        prefix_next     = prefix_reg;
        stopped_next    = stopped_reg;

        pre   = !first_seen_reg && (cap_reg >= LEN_W'(2))
                && (item.in_byte == CH_DOT || item.in_byte == CH_APOS);
        pflag = first_seen_reg ? prefix_reg : pre;

        len_need = {1'b0, length_reg} + (LEN_W+1)'(8) + (pflag ? (LEN_W+1)'(2) : '0);
        stp      = stopped_reg || (cap_reg < LEN_W'(2)) || (len_need >= {1'b0, cap_reg});

        rec          = '0;
        rec.pre      = pre;
        rec.a_kind   = K_NONE;
        rec.b_kind   = K_NONE;
        rec.prefixed = pflag;
        rec.last     = item.in_last;

        if (!stp)
        begin
            if (low == LO_BS)
            begin
                if (held_kind_reg != K_NONE && length_reg != '0)
                begin
                    length_next     = length_reg - LEN_W'(held_count_reg);
                    held_kind_next  = K_NONE;
                    held_count_next = '0;
                    held_char_next  = 8'h00;
                    if (column_reg != '0)
                    begin
                        column_next  = column_reg - 16'd1;
                        col_mod_next = (col_mod_reg == '0) ? RW'(TAB_STOP - 1)
                                                           : col_mod_reg - 1'b1;
                    end
                end
            end
            else
            begin
                rec.a_kind      = held_kind_reg;
                rec.a_char      = held_char_reg;
                rec.a_cnt       = held_count_reg;
                held_kind_next  = new_kind;
                held_char_next  = new_char;
                held_count_next = new_cnt;
                length_next     = length_reg + LEN_W'(new_cnt);
                column_next     = col_sum[15:0];
                if (col_sum[16])
                begin
                    col_mod_next = col_sum[RW-1:0];
                end
                else if (new_kind == K_TAB)
                begin
                    col_mod_next = '0;
                end
                else if (new_cols != '0)
                begin
                    col_mod_next = (col_mod_reg == RW'(TAB_STOP - 1)) ? '0
                                                                      : col_mod_reg + 1'b1;
                end
            end
        end

        if (item.in_last)
        begin
            rec.b_kind = held_kind_next;
            rec.b_char = held_char_next;
            rec.b_cnt  = held_count_next;
        end
        rec.end_mark    = item.in_last && !pre && rec.a_cnt == '0 && rec.b_cnt == '0;
        rec.line_length = item.in_last ? length_next : '0;

        rec_push = accept && (pre || rec.a_cnt != '0 || item.in_last);

        if (accept)
        begin
            first_seen_next = 1'b1;
            prefix_next     = pflag;
            stopped_next    = stp;
            if (item.in_last)
            begin
                column_next     = '0;
                col_mod_next    = '0;
                length_next     = '0;
                held_char_next  = 8'h00;
                held_kind_next  = K_NONE;
                held_count_next = '0;
                first_seen_next = 1'b0;
                prefix_next     = 1'b0;
                stopped_next    = 1'b0;
            end
        end
        else
        begin
            column_next     = column_reg;
            col_mod_next    = col_mod_reg;
            length_next     = length_reg;
            held_char_next  = held_char_reg;
            held_kind_next  = held_kind_reg;
            held_count_next = held_count_reg;
        end

        if (cfg_valid && cfg_ready)
        begin
            cap_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= LEN_W'(1024);
            column_reg     <= '0;
            col_mod_reg    <= '0;
            length_reg     <= '0;
            held_char_reg  <= 8'h00;
            held_kind_reg  <= K_NONE;
            held_count_reg <= '0;
            first_seen_reg <= 1'b0;
            prefix_reg     <= 1'b0;
            stopped_reg    <= 1'b0;
        end
        else
        begin
            cap_reg        <= cap_next;
            column_reg     <= column_next;
            col_mod_reg    <= col_mod_next;
            length_reg     <= length_next;
            held_char_reg  <= held_char_next;
            held_kind_reg  <= held_kind_next;
            held_count_reg <= held_count_next;
            first_seen_reg <= first_seen_next;
            prefix_reg     <= prefix_next;
            stopped_reg    <= stopped_next;
        end
    end

endmodule

// File: hdl/tle_queue.sv
// ----------------------------------------------------------------------------
// tle_queue
// Short record queue between the front and the back of the line escaper.
// ----------------------------------------------------------------------------
module tle_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  tle_pkg::tle_rec_t wr_rec,
    output logic              q_full,
    input  logic              rd_en,
    output tle_pkg::tle_rec_t rd_rec,
    output logic              q_valid
);
    import tle_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    tle_rec_t        mem_reg [QDEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     count_reg, count_next;
    logic            do_wr;
    logic            do_rd;

    assign q_full  = (count_reg == (PW+1)'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && q_valid;
    assign rd_rec  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PW+1)'(QDEPTH))
        else $error("queue count above depth");

endmodule

// File: hdl/tle_back.sv
// ----------------------------------------------------------------------------
// tle_back
// Expands group records into a result register that the consumer pops, one
// output byte per cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
module tle_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tle_pkg::tle_rec_t    q_rec,
    input  logic                 q_valid,
    output logic                 q_pop,
    output logic                 empty,
    input  logic                 pop,
    output tle_pkg::tle_result_t result
);
    import tle_pkg::*;

    logic [1:0]        seg_reg, seg_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    tle_result_t       out_reg, out_next;

    logic [CNT_W-1:0]  cnt [4];
    tle_kind_t         kind [4];
    logic [7:0]        chr [4];
    logic [1:0]        cur;
    logic              later;
    logic              more;
    logic              rec_done;
    logic              step;
    logic [7:0]        byte_sel;

    always_comb
    begin
        cnt[0]  = q_rec.pre ? CNT_W'(2) : '0;
        kind[0] = K_PRE;
        chr[0]  = 8'h00;
        cnt[1]  = q_rec.a_cnt;
        kind[1] = q_rec.a_kind;
        chr[1]  = q_rec.a_char;
        cnt[2]  = q_rec.b_cnt;
        kind[2] = q_rec.b_kind;
        chr[2]  = q_rec.b_char;
        cnt[3]  = q_rec.end_mark ? CNT_W'(1) : '0;
        kind[3] = K_END;
        chr[3]  = 8'h00;
    end

    always_comb
    begin
        cur   = seg_reg;
        later = 1'b0;
        for (int s = 3; s >= 0; s--)
        begin
            if (2'(s) >= seg_reg && cnt[s] != '0)
            begin
                cur = 2'(s);
            end
        end
        for (int s = 0; s < 4; s++)
        begin
            if (2'(s) > cur && cnt[s] != '0)
            begin
                later = 1'b1;
            end
        end
        more     = ({1'b0, idx_reg} + (CNT_W+1)'(1)) < {1'b0, cnt[cur]};
        rec_done = !more && !later;
    end

    always_comb
    begin
        unique case (kind[cur])
            K_PRE:   byte_sel = (idx_reg == '0) ? CH_BSL : CH_AMP;
            K_PASS:  byte_sel = chr[cur];
            K_BSL:   byte_sel = CH_BSL;
            K_TAB:   byte_sel = CH_SP;
            K_SQ:
            begin
                case (idx_reg[1:0])
                    2'd0:    byte_sel = CH_BSL;
                    2'd1:    byte_sel = CH_LPAR;
                    2'd2:    byte_sel = CH_S;
                    default: byte_sel = CH_Q;
                endcase
            end
            default: byte_sel = 8'h00;
        endcase
    end

    assign step  = q_valid && (!out_valid_reg || pop);
    assign q_pop = step && rec_done;
    assign empty = !out_valid_reg;
    assign result = out_reg;

    always_comb
    begin
        seg_next       = seg_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (step)
        begin
            out_valid_next      = 1'b1;
            out_next.out_byte   = byte_sel;
            out_next.byte_valid = (kind[cur] != K_END);
            out_next.out_last   = q_rec.last && rec_done;
            out_next.line_length = (q_rec.last && rec_done) ? q_rec.line_length : '0;
            out_next.prefixed   = q_rec.prefixed;
            if (rec_done)
            begin
                seg_next = '0;
                idx_next = '0;
            end
            else if (more)
            begin
                seg_next = cur;
                idx_next = idx_reg + 1'b1;
            end
            else
            begin
                seg_next = cur + 1'b1;
                idx_next = '0;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seg_reg       <= seg_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_step_loads: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("expanded beat not loaded");

    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.byte_valid) |-> out_reg.out_last)
        else $error("end marker without last");

    a_len_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.out_last) |-> (out_reg.line_length == '0))
        else $error("line length on non-final beat");

endmodule

// File: hdl/troff_line_escaper.sv
// ----------------------------------------------------------------------------
// troff_line_escaper
// Escapes one line of raw bytes for a typesetter: prefix, backslash doubling,
// tab expansion, control escapes and backspace cancelation.
// A byte's group is held in the front until the next byte of the line (or the
// last byte itself) is accepted; the back emits 1 beat per cycle when popped.
// Throughput: 1 input beat per cycle for single-byte groups while the queue has
// room; the 4-entry queue absorbs a long group while the expander emits it.
// Reset: out_capacity returns to 1024, line state clears, queue and result empty.
// ----------------------------------------------------------------------------
module troff_line_escaper #(
    parameter int TAB_STOP = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  tle_pkg::tle_item_t        item,
    output logic                      empty,
    input  logic                      pop,
    output tle_pkg::tle_result_t      result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [tle_pkg::LEN_W-1:0] cfg_data
);
    import tle_pkg::*;

    logic     rec_push;
    tle_rec_t rec;
    logic     q_full;
    logic     q_pop;
    tle_rec_t q_rec;
    logic     q_valid;

    tle_front #(
        .TAB_STOP (TAB_STOP)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .rec_push  (rec_push),
        .rec       (rec),
        .q_full    (q_full)
    );

    tle_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_push),
        .wr_rec  (rec),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_rec  (q_rec),
        .q_valid (q_valid)
    );

    tle_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_rec   (q_rec),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule
